[hw/rtl/fir_pkg.sv]
package fir_pkg;

    localparam int MAX_WIDTH_DEFAULT   = 4096;
    localparam int SAMPLE_BITS_DEFAULT = 16;

    localparam int ROW_BITS        = 14;
    localparam int WIDTH_REG_BITS  = 13;
    localparam int HEIGHT_REG_BITS = 15;
    localparam int CFG_DATA_BITS   = 15;
    localparam int CFG_INDEX_BITS  = 1;
    localparam int CLAMP_BITS      = 16;

    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam int FRAME_WIDTH_RESET  = 1920;
    localparam int FRAME_HEIGHT_RESET = 1080;
    localparam int HEIGHT_LIMIT       = 16384;

    // Up to three results follow one item: pixel above, bottom-row left pixel, final pixel.
    localparam int BND_SLOTS = 3;

endpackage

[hw/rtl/flat_interior_removal_top.sv]
// Boundary extraction on a raster-order mask stream, 4-connected neighborhood.
// Input channel (sample_valid / sample_stall / sample_in) takes one sample per item
// in raster order. Output channel (result_valid / result_stall) gives each pixel once,
// with out_column, out_row and frame_last; a flat pixel comes out as 0.
// The configuration channel (cfg_valid / cfg_ready / cfg_index / cfg_data) sets
// frame_width (index 0) and frame_height (index 1); cfg_ready is always high.
// Throughput: one item per cycle on rows above the bottom row while result_stall is low.
// On the bottom row each item after column 0 gives two results (three on the last
// column), so the single result port cannot keep up there and sample_stall rises.
// Order: a pixel above the bottom row leaves when the sample below it arrives, one row later;
// an item's results enter the result buffer on acceptance, then the output register.
// Each item reads the previous row at its own and its right column and the row before
// at its own column, one item ahead, from three single-port-read line stores.
// While a valid result is stalled the output register and a three-slot result buffer hold,
// and sample_stall is raised as soon as the buffer cannot take another item.
// Reset returns to row 0, column 0 with width 1920 and height 1080. The line stores
// are not cleared; the first row of each frame only fills them.
module flat_interior_removal_top #(
    parameter int MAX_WIDTH   = fir_pkg::MAX_WIDTH_DEFAULT,
    parameter int SAMPLE_BITS = fir_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               sample_valid,
    output logic                               sample_stall,
    input  logic [SAMPLE_BITS-1:0]             sample_in,
    output logic                               result_valid,
    input  logic                               result_stall,
    output logic [SAMPLE_BITS-1:0]             sample_out,
    output logic [$clog2(MAX_WIDTH)-1:0]       out_column,
    output logic [fir_pkg::ROW_BITS-1:0]       out_row,
    output logic                               frame_last,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [fir_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [fir_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int COL_BITS = $clog2(MAX_WIDTH);
    localparam int RB       = fir_pkg::ROW_BITS;
    localparam int CB       = fir_pkg::CLAMP_BITS;
    localparam int NS       = fir_pkg::BND_SLOTS;
    localparam int LASTCOL_RESET =
        ((fir_pkg::FRAME_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : fir_pkg::FRAME_WIDTH_RESET) - 1;
    localparam int LASTROW_RESET = fir_pkg::FRAME_HEIGHT_RESET - 1;

    // Configuration, kept as the last column and last row indexes.
    logic [COL_BITS-1:0] lastcol_reg;
    logic [RB-1:0]       lastrow_reg;
    logic [CB-1:0]       w_ext;
    logic [CB-1:0]       w_clamp;
    logic [CB-1:0]       h_ext;
    logic [CB-1:0]       h_clamp;

    // Position and short history.
    logic [COL_BITS-1:0]    col_reg;
    logic [COL_BITS-1:0]    col_next;
    logic [RB-1:0]          row_reg;
    logic [RB-1:0]          row_next;
    logic [SAMPLE_BITS-1:0] prev_sample_reg;
    logic [SAMPLE_BITS-1:0] prev2_sample_reg;
    logic [SAMPLE_BITS-1:0] left_above_reg;

    // Line store read data.
    logic [SAMPLE_BITS-1:0] a_here;
    logic [SAMPLE_BITS-1:0] a_right;
    logic [SAMPLE_BITS-1:0] b_here;

    // Result buffer and output register.
    logic [1:0]             bnd_count_reg;
    logic [1:0]             new_count;
    logic [SAMPLE_BITS-1:0] bnd_sample_reg [NS];
    logic [COL_BITS-1:0]    bnd_col_reg    [NS];
    logic [RB-1:0]          bnd_row_reg    [NS];
    logic                   bnd_last_reg   [NS];
    logic                   out_valid_reg;
    logic [SAMPLE_BITS-1:0] out_sample_reg;
    logic [COL_BITS-1:0]    out_col_reg;
    logic [RB-1:0]          out_row_reg;
    logic                   out_last_reg;

    logic                   accept;
    logic                   out_free;
    logic                   move;
    logic                   last_col;
    logic                   bottom;
    logic                   res0_flat;
    logic                   res1_flat;
    logic [SAMPLE_BITS-1:0] res0_sample;
    logic [SAMPLE_BITS-1:0] res1_sample;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        w_ext   = CB'(cfg_data[fir_pkg::WIDTH_REG_BITS-1:0]);
        w_clamp = (w_ext < CB'(2)) ? CB'(2) : ((w_ext > CB'(MAX_WIDTH)) ? CB'(MAX_WIDTH) : w_ext);
        h_ext   = CB'(cfg_data[fir_pkg::HEIGHT_REG_BITS-1:0]);
        h_clamp = (h_ext < CB'(2)) ? CB'(2) :
                  ((h_ext > CB'(fir_pkg::HEIGHT_LIMIT)) ? CB'(fir_pkg::HEIGHT_LIMIT) : h_ext);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lastcol_reg <= COL_BITS'(LASTCOL_RESET);
            lastrow_reg <= RB'(LASTROW_RESET);
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == fir_pkg::REG_FRAME_WIDTH)
            begin
                lastcol_reg <= COL_BITS'(w_clamp - CB'(1));
            end
            else if (cfg_index == fir_pkg::REG_FRAME_HEIGHT)
            begin
                lastrow_reg <= RB'(h_clamp - CB'(1));
            end
        end
    end

    // Handshake. The buffer takes a new item once it is empty or its last result leaves now.
    assign out_free     = !out_valid_reg || !result_stall;
    assign move         = out_free && (bnd_count_reg != 2'd0);
    assign sample_stall = !((bnd_count_reg == 2'd0) || ((bnd_count_reg == 2'd1) && out_free));
    assign accept       = sample_valid && !sample_stall;

    always_comb
    begin
        last_col = col_reg >= lastcol_reg;
        bottom   = row_reg >= lastrow_reg;
        col_next = last_col ? '0 : col_reg + COL_BITS'(1);
        row_next = last_col ? (bottom ? '0 : row_reg + RB'(1)) : row_reg;

        // Pixel one row up at this column. Its left neighbor was read one item ago.
        res0_flat = (col_reg != '0) && !last_col
                    && (a_here == left_above_reg) && (a_here == a_right)
                    && (a_here == sample_in)
                    && ((row_reg == RB'(1)) || (a_here == b_here));
        res0_sample = res0_flat ? '0 : a_here;

        // Bottom-row pixel to the left: its left is two samples back, its top was read last item.
        res1_flat = (col_reg > COL_BITS'(1))
                    && (prev_sample_reg == prev2_sample_reg)
                    && (prev_sample_reg == sample_in)
                    && (prev_sample_reg == left_above_reg);
        res1_sample = res1_flat ? '0 : prev_sample_reg;

        if (row_reg == '0)
        begin
            new_count = 2'd0;
        end
        else
        begin
            new_count = 2'd1 + 2'(bottom && (col_reg != '0)) + 2'(bottom && last_col);
        end
    end

    // The stores are read one item ahead at the next column, so data waits in the read register.
    fir_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WIDTH)) u_above_here (
        .clk     (clk),
        .wr_en   (accept),
        .wr_addr (col_reg),
        .wr_data (sample_in),
        .rd_en   (accept),
        .rd_addr (col_next),
        .rd_data (a_here)
    );

    fir_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WIDTH)) u_above_right (
        .clk     (clk),
        .wr_en   (accept),
        .wr_addr (col_reg),
        .wr_data (sample_in),
        .rd_en   (accept),
        .rd_addr (col_next + COL_BITS'(1)),
        .rd_data (a_right)
    );

    fir_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WIDTH)) u_two_above (
        .clk     (clk),
        .wr_en   (accept),
        .wr_addr (col_reg),
        .wr_data (a_here),
        .rd_en   (accept),
        .rd_addr (col_next),
        .rd_data (b_here)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg          <= '0;
            row_reg          <= '0;
            prev_sample_reg  <= '0;
            prev2_sample_reg <= '0;
            bnd_count_reg    <= 2'd0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                col_reg          <= col_next;
                row_reg          <= row_next;
                prev_sample_reg  <= sample_in;
                prev2_sample_reg <= prev_sample_reg;
                bnd_count_reg    <= new_count;
            end
            else if (move)
            begin
                bnd_count_reg <= bnd_count_reg - 2'd1;
            end

            if (move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_free)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            left_above_reg    <= a_here;
            bnd_sample_reg[0] <= res0_sample;
            bnd_col_reg[0]    <= col_reg;
            bnd_row_reg[0]    <= row_reg - RB'(1);
            bnd_last_reg[0]   <= 1'b0;
            bnd_sample_reg[1] <= res1_sample;
            bnd_col_reg[1]    <= col_reg - COL_BITS'(1);
            bnd_row_reg[1]    <= row_reg;
            bnd_last_reg[1]   <= 1'b0;
            bnd_sample_reg[2] <= sample_in;
            bnd_col_reg[2]    <= col_reg;
            bnd_row_reg[2]    <= row_reg;
            bnd_last_reg[2]   <= 1'b1;
        end
        else if (move)
        begin
            for (int i = 0; i < NS - 1; i++)
            begin
                bnd_sample_reg[i] <= bnd_sample_reg[i+1];
                bnd_col_reg[i]    <= bnd_col_reg[i+1];
                bnd_row_reg[i]    <= bnd_row_reg[i+1];
                bnd_last_reg[i]   <= bnd_last_reg[i+1];
            end
        end

        if (move)
        begin
            out_sample_reg <= bnd_sample_reg[0];
            out_col_reg    <= bnd_col_reg[0];
            out_row_reg    <= bnd_row_reg[0];
            out_last_reg   <= bnd_last_reg[0];
        end
    end

    assign result_valid = out_valid_reg;
    assign sample_out   = out_sample_reg;
    assign out_column   = out_col_reg;
    assign out_row      = out_row_reg;
    assign frame_last   = out_last_reg;

endmodule

[hw/rtl/fir_ram.sv]
module fir_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[hw/rtl/fir_checker.sv]
module fir_checker #(
    parameter int MAX_WIDTH   = fir_pkg::MAX_WIDTH_DEFAULT,
    parameter int SAMPLE_BITS = fir_pkg::SAMPLE_BITS_DEFAULT
) (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               result_valid,
    input logic                               result_stall,
    input logic [SAMPLE_BITS-1:0]             sample_out,
    input logic [$clog2(MAX_WIDTH)-1:0]       out_column,
    input logic [fir_pkg::ROW_BITS-1:0]       out_row,
    input logic                               frame_last
);

    // A stalled result keeps its whole payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(sample_out)
            && $stable(out_column) && $stable(out_row) && $stable(frame_last))
        else $error("stalled result changed");

    // The final pixel lies on the bottom row, which is never row 0.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && frame_last |-> out_row != '0)
        else $error("frame end on row 0");

    // The final pixel lies on the last column, which is never column 0.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && frame_last |-> out_column != '0)
        else $error("frame end on column 0");

    // Nothing is offered in the first cycle after reset.
    assert property (@(posedge clk)
        $rose(rst_n) |-> !result_valid)
        else $error("result offered right after reset");

endmodule

bind flat_interior_removal_top fir_checker #(
    .MAX_WIDTH   (MAX_WIDTH),
    .SAMPLE_BITS (SAMPLE_BITS)
) u_fir_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .sample_out   (sample_out),
    .out_column   (out_column),
    .out_row      (out_row),
    .frame_last   (frame_last)
);
